### rtl/mfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mfs_pkg;

	localparam int LEVELS = 4;
	localparam int LVL_W  = 2;
	localparam int ID_W   = 8;
	localparam int TIME_W = 16;
	localparam int QNT_W  = 8;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [LVL_W-1:0] LAST_LEVEL   = 2'd3;
	localparam logic [QNT_W-1:0] QUANTUM_LAST = 8'hFF;

	localparam logic [QNT_W-1:0] QUANTUM0_RST = 8'd1;
	localparam logic [QNT_W-1:0] QUANTUM1_RST = 8'd2;
	localparam logic [QNT_W-1:0] QUANTUM2_RST = 8'd6;
	localparam logic [QNT_W-1:0] QUANTUM_LEFT_RST = 8'd1;

	localparam logic KIND_TICK    = 1'b0;
	localparam logic KIND_ARRIVAL = 1'b1;

	localparam logic [1:0] REG_QUANTUM0 = 2'd0;
	localparam logic [1:0] REG_QUANTUM1 = 2'd1;
	localparam logic [1:0] REG_QUANTUM2 = 2'd2;

	typedef struct packed {
		logic              kind;
		logic [ID_W-1:0]   process_id;
		logic [TIME_W-1:0] time_needed;
	} in_word_t;

	typedef struct packed {
		logic              running_valid;
		logic [ID_W-1:0]   running_id;
		logic [LVL_W-1:0]  running_level;
		logic [TIME_W-1:0] running_time_left;
		logic              arrival_refused;
	} out_word_t;

endpackage

`default_nettype wire

### rtl/mfs_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mfs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/multilevel_feedback_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Word
// in        sink       in_valid / in_ready   mfs_pkg::in_word_t (tick or arrival)
// out       source     out_valid / out_ready mfs_pkg::out_word_t (one per input word)
// cfg       APB slave  psel/penable/pwrite   quantum_level0..2 at 0x0, 0x4, 0x8
//
// Each input word passes an accept cycle and an execute cycle. The accept
// cycle updates FIFO pointers, writes a demoted or arriving slot and issues
// the pop read; the next cycle takes the slot memory's registered read data
// and loads the output register if it is free. The block takes no new word
// until the execute cycle is through and the output register has been loaded.
// Reset clears pointers, counts and the running process; slot memory contents
// are not cleared, since a slot is only read behind a nonzero count.
// A stalled output holds the block in S_WAIT until the result is taken.

module multilevel_feedback_scheduler #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// configuration
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [mfs_pkg::ADDR_W-1:0] paddr,
	input  wire logic [mfs_pkg::DATA_W-1:0] pwdata,
	output      logic [mfs_pkg::DATA_W-1:0] prdata,
	output      logic                       pready,
	// input words
	input  wire logic                       in_valid,
	output      logic                       in_ready,
	input  wire mfs_pkg::in_word_t          in_word,
	// result words
	output      logic                       out_valid,
	input  wire logic                       out_ready,
	output      mfs_pkg::out_word_t         out_word
);

	localparam int IW = $clog2(QUEUE_DEPTH);       // slot index within a level
	localparam int CW = $clog2(QUEUE_DEPTH + 1);   // count up to QUEUE_DEPTH
	localparam int SW = IW + 1;                    // head + count before wrap
	localparam int AW = mfs_pkg::LVL_W + IW;
	localparam int DW = mfs_pkg::ID_W + mfs_pkg::TIME_W;
	localparam int MEM_DEPTH = mfs_pkg::LEVELS << IW;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_WAIT = 3'b100
	} state_t;

	state_t state_q, state_d;

	// configuration registers
	logic [mfs_pkg::QNT_W-1:0] quantum0_q, quantum1_q, quantum2_q;
	logic                      cfg_we;

	// FIFO pointers, one lane per level
	logic [IW-1:0] head_q  [mfs_pkg::LEVELS];
	logic [CW-1:0] count_q [mfs_pkg::LEVELS];
	logic [CW-1:0] held_q;

	// running process
	logic                       cur_valid_q;
	logic [mfs_pkg::ID_W-1:0]   cur_id_q;
	logic [mfs_pkg::TIME_W-1:0] cur_time_q;
	logic [mfs_pkg::LVL_W-1:0]  cur_level_q;
	logic [mfs_pkg::QNT_W-1:0]  quantum_left_q;

	// carried from the accept cycle to the execute cycle
	logic          tick_s1;
	logic          pop_s1;
	logic          fwd_s1;
	logic [DW-1:0] fwd_data_s1;
	logic          refused_q;

	logic               out_valid_q;
	mfs_pkg::out_word_t out_word_q;

	// accept-cycle decode
	logic                      in_fire;
	logic                      is_tick;
	logic                      resched;
	logic                      demote;
	logic                      drop;
	logic                      accept_arr;
	logic                      do_push;
	logic [mfs_pkg::LVL_W-1:0] push_lvl;
	logic [DW-1:0]             push_data;
	logic [SW-1:0]             tail_sum;
	logic [IW-1:0]             tail_idx;
	logic [mfs_pkg::LEVELS-1:0] push_hit;
	logic [mfs_pkg::LEVELS-1:0] pop_hit;
	logic [mfs_pkg::LEVELS-1:0] nonempty;
	logic                      found;
	logic [mfs_pkg::LVL_W-1:0] pop_lvl;
	logic                      do_pop;
	logic                      fwd;
	logic [mfs_pkg::QNT_W-1:0] pop_quantum;

	// memory
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [DW-1:0] mem_rdata;

	// execute-cycle values
	logic [DW-1:0]              slot_word;
	logic                       base_valid;
	logic [mfs_pkg::ID_W-1:0]   base_id;
	logic [mfs_pkg::TIME_W-1:0] base_time;
	logic [mfs_pkg::TIME_W-1:0] nxt_time;
	logic [mfs_pkg::QNT_W-1:0]  nxt_quantum;
	logic                       src_valid;
	logic [mfs_pkg::ID_W-1:0]   src_id;
	logic [mfs_pkg::TIME_W-1:0] src_time;
	logic                       out_free;
	logic                       out_load;

	// ------------------------------------------------------------------
	// APB port: always ready, writes land on the access phase
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum0_q <= mfs_pkg::QUANTUM0_RST;
			quantum1_q <= mfs_pkg::QUANTUM1_RST;
			quantum2_q <= mfs_pkg::QUANTUM2_RST;
		end else if (cfg_we) begin
			unique case (paddr[3:2])
				mfs_pkg::REG_QUANTUM0: quantum0_q <= pwdata[mfs_pkg::QNT_W-1:0];
				mfs_pkg::REG_QUANTUM1: quantum1_q <= pwdata[mfs_pkg::QNT_W-1:0];
				mfs_pkg::REG_QUANTUM2: quantum2_q <= pwdata[mfs_pkg::QNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			mfs_pkg::REG_QUANTUM0: prdata[mfs_pkg::QNT_W-1:0] = quantum0_q;
			mfs_pkg::REG_QUANTUM1: prdata[mfs_pkg::QNT_W-1:0] = quantum1_q;
			mfs_pkg::REG_QUANTUM2: prdata[mfs_pkg::QNT_W-1:0] = quantum2_q;
			default: prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Accept cycle: decide demote / drop / push and pick the level to poll
	// ------------------------------------------------------------------
	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid & in_ready;
	assign is_tick  = (in_word.kind == mfs_pkg::KIND_TICK);

	// reschedule when idle, finished, or out of quantum
	assign resched = (quantum_left_q == '0) || !cur_valid_q || (cur_time_q == '0);
	assign demote  = is_tick && resched && cur_valid_q && (cur_time_q != '0);
	assign drop    = is_tick && resched && cur_valid_q && (cur_time_q == '0) &&
	                 (held_q != '0);
	// the running process is counted in held_q, so no level can overflow
	assign accept_arr = !is_tick && (held_q < CW'(QUEUE_DEPTH));
	assign do_push    = demote || accept_arr;

	always_comb begin
		if (is_tick) begin
			// the last level keeps its own processes
			push_lvl  = (cur_level_q == mfs_pkg::LAST_LEVEL) ? mfs_pkg::LAST_LEVEL :
			            cur_level_q + 1'b1;
			push_data = {cur_id_q, cur_time_q};
		end else begin
			push_lvl  = '0;
			push_data = {in_word.process_id, in_word.time_needed};
		end
	end

	// tail = (head + count) mod depth, one compare and subtract
	assign tail_sum = SW'(head_q[push_lvl]) + SW'(count_q[push_lvl]);
	assign tail_idx = (tail_sum >= SW'(QUEUE_DEPTH)) ?
	                  IW'(tail_sum - SW'(QUEUE_DEPTH)) : IW'(tail_sum);

	// poll against counts after the push
	always_comb begin
		found   = 1'b0;
		pop_lvl = '0;
		for (int l = 0; l < mfs_pkg::LEVELS; l++) begin
			push_hit[l] = do_push && (push_lvl == mfs_pkg::LVL_W'(l));
			nonempty[l] = (count_q[l] != '0) || push_hit[l];
		end
		for (int l = mfs_pkg::LEVELS - 1; l >= 0; l--) begin
			if (nonempty[l]) begin
				found   = 1'b1;
				pop_lvl = mfs_pkg::LVL_W'(l);
			end
		end
	end

	assign do_pop = is_tick && resched && found;

	always_comb begin
		for (int l = 0; l < mfs_pkg::LEVELS; l++) begin
			pop_hit[l] = do_pop && (pop_lvl == mfs_pkg::LVL_W'(l));
		end
	end

	// a slot pushed into an empty level and popped at once sits at the head
	assign fwd = do_pop && push_hit[pop_lvl] && (count_q[pop_lvl] == '0);

	always_comb begin
		case (pop_lvl)
			2'd0:    pop_quantum = quantum0_q;
			2'd1:    pop_quantum = quantum1_q;
			2'd2:    pop_quantum = quantum2_q;
			default: pop_quantum = mfs_pkg::QUANTUM_LAST;
		endcase
	end

	assign mem_we    = in_fire && do_push;
	assign mem_waddr = {push_lvl, tail_idx};
	assign mem_re    = in_fire && do_pop && !fwd;
	assign mem_raddr = {pop_lvl, head_q[pop_lvl]};

	mfs_ram #(
		.WIDTH (DW),
		.DEPTH (MEM_DEPTH)
	) u_slot_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (push_data),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// FIFO pointers and held count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < mfs_pkg::LEVELS; l++) begin
				head_q[l]  <= '0;
				count_q[l] <= '0;
			end
			held_q <= '0;
		end else if (in_fire) begin
			for (int l = 0; l < mfs_pkg::LEVELS; l++) begin
				if (pop_hit[l]) begin
					head_q[l] <= (head_q[l] == IW'(QUEUE_DEPTH - 1)) ? '0 :
					             head_q[l] + 1'b1;
				end
				count_q[l] <= count_q[l] + CW'(push_hit[l]) - CW'(pop_hit[l]);
			end
			if (accept_arr) begin
				held_q <= held_q + 1'b1;
			end else if (drop) begin
				held_q <= held_q - 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Execute cycle: take the popped slot, then spend one tick if the word was a tick
	// ------------------------------------------------------------------
	assign slot_word  = fwd_s1 ? fwd_data_s1 : mem_rdata;
	assign base_valid = pop_s1 | cur_valid_q;
	assign base_id    = pop_s1 ? slot_word[DW-1:mfs_pkg::TIME_W] : cur_id_q;
	assign base_time  = pop_s1 ? slot_word[mfs_pkg::TIME_W-1:0] : cur_time_q;

	// both decrements saturate at zero; the last level keeps its quantum
	assign nxt_time = (tick_s1 && base_valid && (base_time != '0)) ?
	                  base_time - 1'b1 : base_time;
	assign nxt_quantum = (tick_s1 && base_valid && (cur_level_q != mfs_pkg::LAST_LEVEL) &&
	                      (quantum_left_q != '0)) ? quantum_left_q - 1'b1 : quantum_left_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q    <= 1'b0;
			cur_level_q    <= '0;
			quantum_left_q <= mfs_pkg::QUANTUM_LEFT_RST;
		end else if (in_fire) begin
			if (is_tick && resched) begin
				// release the old process; a popped one is installed next cycle
				cur_valid_q <= 1'b0;
				if (do_pop) begin
					cur_level_q    <= pop_lvl;
					quantum_left_q <= pop_quantum;
				end
			end
		end else if (state_q == S_EXEC) begin
			cur_valid_q    <= base_valid;
			quantum_left_q <= nxt_quantum;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EXEC) begin
			cur_id_q   <= base_id;
			cur_time_q <= nxt_time;
		end
		if (in_fire) begin
			tick_s1     <= is_tick;
			fwd_s1      <= fwd;
			fwd_data_s1 <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop_s1    <= 1'b0;
			refused_q <= 1'b0;
		end else if (in_fire) begin
			pop_s1    <= do_pop;
			refused_q <= !is_tick && !accept_arr;
		end
	end

	// ------------------------------------------------------------------
	// Output register: load in the execute cycle if free, else once free in S_WAIT
	// ------------------------------------------------------------------
	assign out_free = !out_valid_q || out_ready;
	assign out_load = ((state_q == S_EXEC) || (state_q == S_WAIT)) && out_free;

	always_comb begin
		if (state_q == S_EXEC) begin
			src_valid = base_valid;
			src_id    = base_id;
			src_time  = nxt_time;
		end else begin
			src_valid = cur_valid_q;
			src_id    = cur_id_q;
			src_time  = cur_time_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_word_q.running_valid     <= src_valid;
			out_word_q.running_id        <= src_valid ? src_id : '0;
			out_word_q.running_level     <= src_valid ? cur_level_q : '0;
			out_word_q.running_time_left <= src_valid ? src_time : '0;
			out_word_q.arrival_refused   <= refused_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_fire) state_d = S_EXEC;
			S_EXEC: state_d = out_free ? S_IDLE : S_WAIT;
			S_WAIT: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

### rtl/mfs_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module mfs_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire mfs_pkg::out_word_t out_word
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("result word changed while stalled");

	// one word at a time: an accepted word closes the input for the next cycle
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a word is in flight");

	// a new result only follows work that kept the input closed
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a word in flight");

	// an idle result reports all-zero process fields
	a_idle_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.running_valid |->
			(out_word.running_id == '0) && (out_word.running_level == '0) &&
			(out_word.running_time_left == '0))
		else $error("idle result carries process fields");

endmodule

bind multilevel_feedback_scheduler mfs_checker u_mfs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_word  (out_word)
);

`default_nettype wire

### tb/mfs_schedule_checker.sv
`timescale 1ns / 1ps

// Watches the input, result and register ports of the scheduler, predicts
// one result word per input word and compares each result field by field.
module mfs_schedule_checker
	import mfs_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic              pready,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	input  wire logic              in_valid,
	input  wire logic              in_ready,
	input  wire in_word_t          in_word,
	input  wire logic              out_valid,
	input  wire logic              out_ready,
	input  wire out_word_t         out_word,
	output int                     errors,
	output int                     waiting
);

	logic [QNT_W-1:0]  quantum [3];
	logic [ID_W-1:0]   slot_id   [LEVELS][QUEUE_DEPTH];
	logic [TIME_W-1:0] slot_time [LEVELS][QUEUE_DEPTH];
	int                lvl_head  [LEVELS];
	int                lvl_count [LEVELS];
	int                procs_held;
	logic              run_valid;
	logic [ID_W-1:0]   run_id;
	logic [TIME_W-1:0] run_time;
	logic [LVL_W-1:0]  run_level;
	logic [QNT_W-1:0]  ticks_left;
	out_word_t         expected_runs [$];

	function automatic void enqueue(int lvl, logic [ID_W-1:0] id, logic [TIME_W-1:0] t);
		int pos;
		if (lvl_count[lvl] >= QUEUE_DEPTH)
			return;
		pos = (lvl_head[lvl] + lvl_count[lvl]) % QUEUE_DEPTH;
		slot_id[lvl][pos]   = id;
		slot_time[lvl][pos] = t;
		lvl_count[lvl]++;
	endfunction

	task automatic schedule_word(input in_word_t w, output out_word_t r);
		logic refused;
		int   h;
		refused = 1'b0;
		if (w.kind == KIND_ARRIVAL) begin
			if (procs_held >= QUEUE_DEPTH) begin
				refused = 1'b1;
			end else begin
				enqueue(0, w.process_id, w.time_needed);
				procs_held++;
			end
		end else begin
			if (ticks_left == 0 || !run_valid || run_time == 0) begin
				// demote an unfinished process, the last level keeps it
				if (run_valid) begin
					if (run_time != 0)
						enqueue((run_level == LAST_LEVEL) ? LAST_LEVEL : run_level + 2'd1,
							run_id, run_time);
					else if (procs_held > 0)
						procs_held--;
				end
				run_valid = 1'b0;
				run_id    = '0;
				run_time  = '0;
				for (int l = 0; l < LEVELS; l++) begin
					if (!run_valid && lvl_count[l] != 0) begin
						h            = lvl_head[l];
						run_id       = slot_id[l][h];
						run_time     = slot_time[l][h];
						lvl_head[l]  = (h + 1) % QUEUE_DEPTH;
						lvl_count[l]--;
						run_valid    = 1'b1;
						run_level    = LVL_W'(l);
						ticks_left   = (l == LAST_LEVEL) ? QUANTUM_LAST : quantum[l];
					end
				end
			end
			if (run_valid) begin
				if (run_level != LAST_LEVEL && ticks_left != 0)
					ticks_left--;
				if (run_time != 0)
					run_time--;
			end
		end
		r.running_valid     = run_valid;
		r.running_id        = run_valid ? run_id : '0;
		r.running_level     = run_valid ? run_level : '0;
		r.running_time_left = run_valid ? run_time : '0;
		r.arrival_refused   = refused;
	endtask

	function automatic bit field_ok(string name, int unsigned want, int unsigned got);
		if (want == got)
			return 1'b1;
		$error("%s: expected %0d, got %0d", name, want, got);
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		out_word_t next;
		bit        ok;
		if (!arst_n) begin
			quantum[0] = QUANTUM0_RST;
			quantum[1] = QUANTUM1_RST;
			quantum[2] = QUANTUM2_RST;
			for (int l = 0; l < LEVELS; l++) begin
				lvl_head[l]  = 0;
				lvl_count[l] = 0;
			end
			procs_held = 0;
			run_valid  = 1'b0;
			run_id     = '0;
			run_time   = '0;
			run_level  = '0;
			ticks_left = QUANTUM_LEFT_RST;
			expected_runs.delete();
			errors  = 0;
			waiting = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_QUANTUM0: quantum[0] = pwdata[QNT_W-1:0];
					REG_QUANTUM1: quantum[1] = pwdata[QNT_W-1:0];
					REG_QUANTUM2: quantum[2] = pwdata[QNT_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_runs.size() == 0) begin
					$error("result word with no input word pending");
					errors++;
				end else begin
					want = expected_runs.pop_front();
					ok = field_ok("running_valid", want.running_valid, out_word.running_valid)
						& field_ok("running_id", want.running_id, out_word.running_id)
						& field_ok("running_level", want.running_level, out_word.running_level)
						& field_ok("running_time_left", want.running_time_left,
							out_word.running_time_left)
						& field_ok("arrival_refused", want.arrival_refused,
							out_word.arrival_refused);
					if (!ok)
						errors++;
				end
			end
			if (in_valid && in_ready) begin
				schedule_word(in_word, next);
				expected_runs.push_back(next);
			end
			waiting = expected_runs.size();
		end
	end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import mfs_pkg::*;

	// Cycles without any word moving before the run is called hung. The slowest
	// correct gap is one sender gap, the block's accept and execute cycles and one receiver stall.
	localparam int STALL_LIMIT = 500;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid;
	logic              in_ready;
	in_word_t          in_word;
	logic              out_valid;
	logic              out_ready;
	out_word_t         out_word;
	int                errors;
	int                waiting;
	int                stalled;

	// idle stretches: each side draws calm runs (no gaps) or busy runs at random
	int                in_left  = 0;
	bit                in_calm  = 1'b0;
	int                out_left = 0;
	bit                out_calm = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	multilevel_feedback_scheduler #(
		.QUEUE_DEPTH(16)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word (out_word)
	);

	mfs_schedule_checker #(
		.QUEUE_DEPTH(16)
	) u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.pready   (pready),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word (out_word),
		.errors   (errors),
		.waiting  (waiting)
	);

	// Draw the wait before the next word; pick calm or busy at random for each new run.
	function automatic int idle_draw(inout int left, inout bit calm);
		if (left == 0) begin
			left = $urandom_range(8, 40);
			calm = ($urandom_range(0, 3) == 0);
		end
		left--;
		return calm ? 0 : $urandom_range(0, 12);
	endfunction

	// Mostly short jobs so processes finish and free the store; wide draws
	// reach the top bits of the work field but can pin the last level.
	function automatic logic [TIME_W-1:0] work_draw(bit wide);
		if (wide && $urandom_range(0, 19) == 0)
			return TIME_W'($urandom_range(1, 65535));
		if ($urandom_range(0, 3) == 0)
			return TIME_W'($urandom_range(1, 64));
		return TIME_W'($urandom_range(1, 8));
	endfunction

	function automatic in_word_t arrival_word(logic [ID_W-1:0] id, logic [TIME_W-1:0] t);
		in_word_t w;
		w.kind        = KIND_ARRIVAL;
		w.process_id  = id;
		w.time_needed = t;
		return w;
	endfunction

	// Tick words carry random payload that the block must ignore.
	function automatic in_word_t tick_word();
		in_word_t w;
		w.kind        = KIND_TICK;
		w.process_id  = ID_W'($urandom);
		w.time_needed = TIME_W'($urandom);
		return w;
	endfunction

	// Starts and ends at a falling edge; hold valid and payload until taken.
	task automatic send_word(input in_word_t w);
		int gap;
		gap = idle_draw(in_left, in_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		do @(posedge clk); while (!(in_valid && in_ready));
		@(negedge clk);
	endtask

	// Bursts of arrivals followed by runs of ticks, so the store fills, spills
	// into refusals and drains through every level; some segments mix at random.
	// Stop exactly at the requested word count.
	task automatic run_mix(int count, bit wide);
		int sent;
		int n;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 10);
				if (n > count - sent)
					n = count - sent;
				repeat (n) begin
					if ($urandom_range(0, 1) == 1)
						send_word(arrival_word(ID_W'($urandom), work_draw(wide)));
					else
						send_word(tick_word());
				end
				sent += n;
			end else begin
				n = $urandom_range(1, 18);
				if (n > count - sent)
					n = count - sent;
				repeat (n)
					send_word(arrival_word(ID_W'($urandom), work_draw(wide)));
				sent += n;
				n = $urandom_range(1, 60);
				if (n > count - sent)
					n = count - sent;
				repeat (n)
					send_word(tick_word());
				sent += n;
			end
		end
	endtask

	// Drop valid, wait for every result word, then let the block settle.
	task automatic quiesce(int extra);
		in_valid <= 1'b0;
		while (waiting != 0)
			@(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	// Result side: stall a drawn number of cycles, then hold ready until a word moves.
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = idle_draw(out_left, out_calm);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			@(negedge clk);
		end
	end

	// Hang detection: count cycles in which no word moves on any port.
	always @(posedge clk) begin
		if (!arst_n) begin
			stalled <= 0;
		end else if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
			stalled <= 0;
		end else if (stalled >= STALL_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end else begin
			stalled <= stalled + 1;
		end
	end

	initial begin
		logic [1:0]       reg_codes [3];
		logic [QNT_W-1:0] q [3];
		reg_codes = '{REG_QUANTUM0, REG_QUANTUM1, REG_QUANTUM2};
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		in_valid = 1'b0;
		in_word  = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, reset quanta. Tick with an empty store first.
		send_word(tick_word());
		// zero-work job, extreme ids, then fill the store to its limit
		send_word(arrival_word(8'd0, 16'd0));
		send_word(arrival_word(8'd255, 16'd1));
		send_word(arrival_word(8'h5A, 16'd3));
		for (int i = 0; i < 13; i++)
			send_word(arrival_word(ID_W'(i + 1), 16'd2));
		// store full: this one must be refused, all payload bits high
		send_word(arrival_word(8'hFF, 16'hFFFF));
		// run the zero-work job, drop finished ones, demote on quantum expiry
		repeat (8)
			send_word(tick_word());

		// Random phases, each under its own set of quanta.
		for (int p = 0; p < 5; p++) begin
			case (p)
				0: q = '{8'd255, 8'd255, 8'd255};
				1: q = '{8'd1, 8'd1, 8'd1};
				// zero quantum on level 0 should behave like one tick
				2: q = '{8'd0, 8'd3, 8'd1};
				3: begin
					foreach (q[r])
						q[r] = QNT_W'($urandom_range(1, 255));
				end
				default: begin
					foreach (q[r])
						q[r] = QNT_W'($urandom_range(1, 4));
				end
			endcase
			quiesce(4);
			for (int r = 0; r < 3; r++) begin
				psel    <= 1'b1;
				pwrite  <= 1'b1;
				penable <= 1'b0;
				paddr   <= {reg_codes[r], 2'b00};
				pwdata  <= DATA_W'(q[r]);
				@(negedge clk);
				penable <= 1'b1;
				@(negedge clk);
				psel    <= 1'b0;
				penable <= 1'b0;
				pwrite  <= 1'b0;
				@(negedge clk);
			end
			run_mix(221, 1'b0);
		end
		// long jobs last: one of them may hold the last level to the end
		run_mix(20, 1'b1);

		quiesce(16);
		if (errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
